@@ design/stx_pkg.sv @@
// ----------------------------------------------------------------------------
// stx_pkg
// Shared types, phase codes, keyword table and character helpers for the
// SQL target table extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package stx_pkg;

    localparam int MAX_NAME_LEN = 255;
    localparam int NC_W         = $clog2(MAX_NAME_LEN + 1);
    localparam logic [NC_W-1:0] NC_MAX = NC_W'(MAX_NAME_LEN);

    localparam int PEND_DEPTH = 5;
    localparam int PC_W       = $clog2(PEND_DEPTH + 1);
    localparam int WIN_DEPTH  = 5;
    localparam int RIDX_W     = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int PH_W = 5;
    localparam logic [PH_W-1:0] PH_LEAD       = 5'd0;
    localparam logic [PH_W-1:0] PH_K_SELECT   = 5'd1;
    localparam logic [PH_W-1:0] PH_K_INSERT   = 5'd2;
    localparam logic [PH_W-1:0] PH_K_UPDATE   = 5'd3;
    localparam logic [PH_W-1:0] PH_K_DELETE   = 5'd4;
    localparam logic [PH_W-1:0] PH_K_DROP     = 5'd5;
    localparam logic [PH_W-1:0] PH_K_TRUNCATE = 5'd6;
    localparam logic [PH_W-1:0] PH_K_RECLAIM  = 5'd7;
    localparam logic [PH_W-1:0] PH_SCAN       = 5'd8;
    localparam logic [PH_W-1:0] PH_OPT_INTO   = 5'd9;
    localparam logic [PH_W-1:0] PH_OPT_FROM   = 5'd10;
    localparam logic [PH_W-1:0] PH_REQ_TABLE  = 5'd11;
    localparam logic [PH_W-1:0] PH_OPT_IF     = 5'd12;
    localparam logic [PH_W-1:0] PH_OPT_EXISTS = 5'd13;
    localparam logic [PH_W-1:0] PH_OPT_TABLE  = 5'd14;
    localparam logic [PH_W-1:0] PH_NAME_START = 5'd15;
    localparam logic [PH_W-1:0] PH_NAME       = 5'd16;
    localparam logic [PH_W-1:0] PH_DONE       = 5'd17;

    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_KEY  = 2'd1;
    localparam logic [1:0] WK_OPT  = 2'd2;
    localparam logic [1:0] WK_REQ  = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic RK_NAME    = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    typedef struct packed {
        logic [63:0]     text;
        logic [3:0]      len;
        logic [PH_W-1:0] next;
        logic [1:0]      kind;
    } word_info_t;

    typedef struct packed {
        logic [PEND_DEPTH-1:0][7:0] rep_bytes;
        logic [PC_W-1:0]            rep_n;
        logic                       cur_emit;
        logic [7:0]                 cur_byte;
        logic                       verdict;
        logic                       found;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       found;
        logic       last;
    } result_t;

    function automatic word_info_t word_info(input logic [PH_W-1:0] ph);
        word_info_t w;
        w = '0;
        unique case (ph)
            PH_K_SELECT:   w = '{{"SELECT", 16'h0}, 4'd6, PH_SCAN, WK_KEY};
            PH_K_INSERT:   w = '{{"INSERT", 16'h0}, 4'd6, PH_OPT_INTO, WK_KEY};
            PH_K_UPDATE:   w = '{{"UPDATE", 16'h0}, 4'd6, PH_NAME_START, WK_KEY};
            PH_K_DELETE:   w = '{{"DELETE", 16'h0}, 4'd6, PH_OPT_FROM, WK_KEY};
            PH_K_DROP:     w = '{{"DROP", 32'h0}, 4'd4, PH_REQ_TABLE, WK_KEY};
            PH_K_TRUNCATE: w = '{"TRUNCATE", 4'd8, PH_OPT_TABLE, WK_KEY};
            PH_K_RECLAIM:  w = '{{"RECLAIM", 8'h0}, 4'd7, PH_OPT_TABLE, WK_KEY};
            PH_OPT_INTO:   w = '{{"INTO", 32'h0}, 4'd4, PH_NAME_START, WK_OPT};
            PH_OPT_FROM:   w = '{{"FROM", 32'h0}, 4'd4, PH_NAME_START, WK_OPT};
            PH_REQ_TABLE:  w = '{{"TABLE", 24'h0}, 4'd5, PH_OPT_IF, WK_REQ};
            PH_OPT_IF:     w = '{{"IF", 48'h0}, 4'd2, PH_OPT_EXISTS, WK_OPT};
            PH_OPT_EXISTS: w = '{{"EXISTS", 16'h0}, 4'd6, PH_NAME_START, WK_OPT};
            PH_OPT_TABLE:  w = '{{"TABLE", 24'h0}, 4'd5, PH_NAME_START, WK_OPT};
            default:       w = '{64'h0, 4'd0, PH_LEAD, WK_NONE};
        endcase
        return w;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_ws(c) || (c == CH_LPAREN) || (c == CH_SEMI) || (c == CH_COMMA);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [PC_W-1:0] replay_len(input logic [PC_W-1:0] pc);
        return (32'(pc) > MAX_NAME_LEN) ? PC_W'(MAX_NAME_LEN) : pc;
    endfunction

endpackage

`default_nettype wire

@@ design/stx_front.sv @@
// ----------------------------------------------------------------------------
// stx_front
// Statement parser: takes one byte per item, tracks the keyword phase and
// builds one output job per item that gives results.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_front
    import stx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire q_status_t  q_status,
    output logic            push,
    output job_t            job
);

    logic [PH_W-1:0]                 phase_reg, phase_next;
    logic [2:0]                      kpos_reg, kpos_next;
    logic [WIN_DEPTH-1:0][7:0]       win_reg, win_next;
    logic [PEND_DEPTH-1:0][7:0]      pend_reg, pend_next;
    logic [PC_W-1:0]                 pcnt_reg, pcnt_next;
    logic [NC_W-1:0]                 ncnt_reg, ncnt_next;
    logic                            quoted_reg, quoted_next;

    word_info_t      wi;
    logic [63:0]     text_sh;
    logic [7:0]      kw_char;
    logic [7:0]      uc;
    logic [PC_W-1:0] rep_cnt;
    logic            do_start, do_bare, do_emit;
    logic            cur_emit, verdict, found;
    logic            accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    assign uc      = upcase(in_byte);
    assign wi      = word_info(phase_reg);
    assign text_sh = wi.text << {kpos_reg, 3'b000};
    assign kw_char = text_sh[63:56];

    always_comb begin
        phase_next  = phase_reg;
        kpos_next   = kpos_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        ncnt_next   = ncnt_reg;
        quoted_next = quoted_reg;
        win_next    = {in_byte, win_reg[WIN_DEPTH-1:1]};
        do_start    = 1'b0;
        do_bare     = 1'b0;
        do_emit     = 1'b0;
        rep_cnt     = '0;
        cur_emit    = 1'b0;
        verdict     = 1'b0;
        found       = 1'b0;

        if (in_byte == CH_NUL) begin
            if (pcnt_reg != '0) begin
                rep_cnt     = replay_len(pcnt_reg);
                ncnt_next   = NC_W'(rep_cnt);
                pcnt_next   = '0;
                kpos_next   = '0;
                quoted_next = 1'b0;
            end
            phase_next = PH_DONE;
        end else if (phase_reg != PH_DONE) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (!is_ws(in_byte)) begin
                        kpos_next = 3'd1;
                        unique case (uc)
                            "S":     phase_next = PH_K_SELECT;
                            "I":     phase_next = PH_K_INSERT;
                            "U":     phase_next = PH_K_UPDATE;
                            "D":     phase_next = PH_K_DELETE;
                            "T":     phase_next = PH_K_TRUNCATE;
                            "R":     phase_next = PH_K_RECLAIM;
                            default: begin
                                phase_next = PH_DONE;
                                kpos_next  = '0;
                            end
                        endcase
                    end
                end
                PH_SCAN: begin
                    if (is_ws(in_byte) && is_ws(win_reg[0]) &&
                        upcase(win_reg[1]) == "F" && upcase(win_reg[2]) == "R" &&
                        upcase(win_reg[3]) == "O" && upcase(win_reg[4]) == "M") begin
                        phase_next = PH_NAME_START;
                    end
                end
                PH_NAME_START: begin
                    do_start = 1'b1;
                end
                PH_NAME: begin
                    if (quoted_reg) begin
                        if (in_byte == CH_DQUOTE) begin
                            phase_next = PH_DONE;
                        end else begin
                            do_emit = 1'b1;
                        end
                    end else begin
                        do_bare = 1'b1;
                    end
                end
                default: begin
                    if (phase_reg == PH_K_DELETE && kpos_reg == 3'd1 && uc == "R") begin
                        phase_next = PH_K_DROP;
                        kpos_next  = 3'd2;
                    end else if (wi.kind != WK_KEY && kpos_reg == '0 && is_ws(in_byte)) begin
                        phase_next = phase_reg;
                    end else if ({1'b0, kpos_reg} < wi.len && uc == kw_char) begin
                        if (wi.kind == WK_OPT && 32'(kpos_reg) < PEND_DEPTH) begin
                            pend_next[kpos_reg] = in_byte;
                            pcnt_next           = PC_W'(kpos_reg + 3'd1);
                        end
                        if ({1'b0, kpos_reg} + 4'd1 >= wi.len) begin
                            phase_next = wi.next;
                            kpos_next  = '0;
                            pcnt_next  = '0;
                        end else begin
                            kpos_next = kpos_reg + 3'd1;
                        end
                    end else if (wi.kind != WK_OPT) begin
                        phase_next = PH_DONE;
                    end else if (pcnt_reg != '0) begin
                        rep_cnt     = replay_len(pcnt_reg);
                        ncnt_next   = NC_W'(rep_cnt);
                        pcnt_next   = '0;
                        kpos_next   = '0;
                        quoted_next = 1'b0;
                        if (32'(rep_cnt) >= MAX_NAME_LEN) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_NAME;
                            do_bare    = 1'b1;
                        end
                    end else begin
                        kpos_next  = '0;
                        phase_next = PH_NAME_START;
                        do_start   = 1'b1;
                    end
                end
            endcase
        end

        if (do_start && !is_ws(in_byte)) begin
            phase_next = PH_NAME;
            if (in_byte == CH_DQUOTE) begin
                quoted_next = 1'b1;
            end else begin
                quoted_next = 1'b0;
                do_bare     = 1'b1;
            end
        end

        if (do_bare) begin
            if (is_term(in_byte)) begin
                phase_next = PH_DONE;
            end else begin
                do_emit = 1'b1;
            end
        end

        if (do_emit) begin
            if (ncnt_next < NC_MAX) begin
                cur_emit  = 1'b1;
                ncnt_next = ncnt_next + 1'b1;
            end
            if (ncnt_next >= NC_MAX) begin
                phase_next = PH_DONE;
            end
        end

        if (in_last) begin
            if (pcnt_next != '0) begin
                rep_cnt   = replay_len(pcnt_next);
                ncnt_next = NC_W'(rep_cnt);
            end
            verdict     = 1'b1;
            found       = (ncnt_next != '0);
            phase_next  = PH_LEAD;
            kpos_next   = '0;
            win_next    = '0;
            pcnt_next   = '0;
            ncnt_next   = '0;
            quoted_next = 1'b0;
        end
    end

    assign job.rep_bytes = pend_next;
    assign job.rep_n     = rep_cnt;
    assign job.cur_emit  = cur_emit;
    assign job.cur_byte  = in_byte;
    assign job.verdict   = verdict;
    assign job.found     = found;

    assign push = accept && ((rep_cnt != '0) || cur_emit || verdict);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            kpos_reg   <= '0;
            win_reg    <= '0;
            pcnt_reg   <= '0;
            ncnt_reg   <= '0;
            quoted_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kpos_reg   <= kpos_next;
            win_reg    <= win_next;
            pcnt_reg   <= pcnt_next;
            ncnt_reg   <= ncnt_next;
            quoted_reg <= quoted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

@@ design/stx_queue.sv @@
// ----------------------------------------------------------------------------
// stx_queue
// Short job queue between the parser and the result serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_queue
    import stx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire job_t  job_in,
    input  wire logic  pop,
    output job_t       job_out,
    output q_status_t  status
);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign job_out      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

`default_nettype wire

@@ design/stx_back.sv @@
// ----------------------------------------------------------------------------
// stx_back
// Result serialiser: walks each job and, while the receiver is not stalling,
// gives one result per cycle into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_back
    import stx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_empty,
    input  wire job_t  job_in,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    job_t              job_reg;
    logic              job_valid_reg, job_valid_next;
    logic [RIDX_W-1:0] idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg;
    result_t           res_cur;
    logic [RIDX_W-1:0] last_idx;
    logic              out_load;
    logic              job_done;

    assign last_idx = RIDX_W'(RIDX_W'(job_reg.rep_n) + RIDX_W'(job_reg.cur_emit)
                              + RIDX_W'(job_reg.verdict) - 3'd1);

    always_comb begin
        res_cur      = '0;
        res_cur.last = (idx_reg == last_idx);
        if (idx_reg < RIDX_W'(job_reg.rep_n)) begin
            res_cur.kind      = RK_NAME;
            res_cur.name_byte = job_reg.rep_bytes[idx_reg];
        end else if (idx_reg == RIDX_W'(job_reg.rep_n) && job_reg.cur_emit) begin
            res_cur.kind      = RK_NAME;
            res_cur.name_byte = job_reg.cur_byte;
        end else begin
            res_cur.kind  = RK_VERDICT;
            res_cur.found = job_reg.found;
        end
    end

    assign out_load = job_valid_reg && (!m_valid_reg || out_ready);
    assign job_done = out_load && res_cur.last;
    assign pop      = !q_empty && (!job_valid_reg || job_done);

    always_comb begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        if (out_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            idx_next     = idx_reg + 1'b1;
        end
        if (job_done) begin
            job_valid_next = 1'b0;
        end
        if (pop) begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job_in;
        end
        if (out_load) begin
            res_reg <= res_cur;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ design/sql_target_table_extractor.sv @@
// ----------------------------------------------------------------------------
// sql_target_table_extractor
// Streams the target table name out of an SQL statement, one byte per item.
//
// Input channel (s_): one statement byte per item in s_tdata, s_tlast on the
// statement's last byte. Result channel (m_): m_tuser low gives a name byte
// in m_tdata[7:0]; m_tuser high gives the verdict with found in m_tdata[8].
// m_tlast marks the last result caused by one input item.
// The parser takes one byte per cycle while the queue is not full and writes a
// job into a four-entry queue whenever a byte gives results; the serialiser
// drains one result per cycle through an output register while the receiver is ready.
// Results pass through the queue, the job register and the output register.
// Throughput: one item per cycle while items give at most one result each and
// the receiver is ready; an item giving n results holds the result channel until
// all n are taken, and the input side runs until the queue holds four pending jobs.
// Reset (aresetn low, synchronous) returns the parser to the start of a
// statement and empties the queue and the output register.
// A stalled receiver holds the current result stable; s_tready falls only
// when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_target_table_extractor
    import stx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stmt_byte
    input  wire logic        s_tlast,   // end_of_stmt
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] name_byte, [8] found, [15:9] zero
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // last_of_run
);

    q_status_t q_status;
    job_t      job_push;
    job_t      job_head;
    logic      push;
    logic      pop;
    result_t   res;

    stx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .job      (job_push)
    );

    stx_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .job_in  (job_push),
        .pop     (pop),
        .job_out (job_head),
        .status  (q_status)
    );

    stx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_status.empty),
        .job_in    (job_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'b0, res.found, res.name_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ design/stx_checker.sv @@
// ----------------------------------------------------------------------------
// stx_checker
// Port-level checks on the result channel of the table extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_verdict_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("verdict not last of run or carries a name byte");

    a_name_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[8] && (m_tdata[15:9] == 7'h00))
        else $error("name byte result carries found or padding bits");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sql_target_table_extractor stx_checker u_stx_checker (.*);

`default_nettype wire

@@ sim/sql_target_table_extractor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sql_target_table_extractor_tb
// Feeds SQL statement text into the extractor one byte per item and checks
// every name byte and verdict on the result stream. A scoreboard predicts the
// results from its own parser model. The run covers directed corner cases,
// then mostly well-formed random statements with some noise, under changing
// sender and receiver idle rates and one long receiver hold-off.
// ----------------------------------------------------------------------------

module sql_target_table_extractor_tb;
    import stx_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] name_chr;
        logic       found;
        logic       last;
    } name_result_t;

    class table_name_board;
        logic [PH_W-1:0] phase;
        int              kw_pos;
        logic [7:0]      window [5];
        logic [7:0]      held [5];
        int              held_n;
        int              name_n;
        bit              quoted;
        name_result_t    step_q[$];
        name_result_t    awaited[$];
        int              failures;

        function new();
            clear_state();
            failures = 0;
        endfunction

        function void clear_state();
            int i;
            phase  = PH_LEAD;
            kw_pos = 0;
            for (i = 0; i < 5; i++) begin
                window[i] = 8'h00;
                held[i]   = 8'h00;
            end
            held_n = 0;
            name_n = 0;
            quoted = 0;
        endfunction

        function bit blank(input logic [7:0] c);
            return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function logic [7:0] caps(input logic [7:0] c);
            return (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        function void put(input logic kind, input logic [7:0] b, input logic f);
            name_result_t r;
            r.kind     = kind;
            r.name_chr = b;
            r.found    = f;
            r.last     = 1'b0;
            step_q.push_back(r);
        endfunction

        function void name_out(input logic [7:0] c);
            if (name_n < MAX_NAME_LEN) begin
                put(RK_NAME, c, 1'b0);
                name_n++;
            end
            if (name_n >= MAX_NAME_LEN) phase = PH_DONE;
        endfunction

        function void bare(input logic [7:0] c);
            if (blank(c) || c == CH_LPAREN || c == CH_SEMI || c == CH_COMMA)
                phase = PH_DONE;
            else
                name_out(c);
        endfunction

        function void name_begin(input logic [7:0] c);
            if (blank(c)) return;
            phase = PH_NAME;
            if (c == CH_DQUOTE) begin
                quoted = 1;
            end else begin
                quoted = 0;
                bare(c);
            end
        endfunction

        // replay a partly matched optional word as the head of the name
        function void flush_held();
            int i;
            phase  = PH_NAME;
            quoted = 0;
            for (i = 0; i < held_n && i < 5 && phase == PH_NAME; i++) bare(held[i]);
            held_n = 0;
            kw_pos = 0;
        endfunction

        function void lead(input logic [7:0] c);
            if (blank(c)) return;
            kw_pos = 1;
            case (caps(c))
                "S": phase = PH_K_SELECT;
                "I": phase = PH_K_INSERT;
                "U": phase = PH_K_UPDATE;
                "D": phase = PH_K_DELETE;
                "T": phase = PH_K_TRUNCATE;
                "R": phase = PH_K_RECLAIM;
                default: begin
                    phase  = PH_DONE;
                    kw_pos = 0;
                end
            endcase
        endfunction

        function void scan(input logic [7:0] c);
            if (blank(c) && blank(window[0]) && caps(window[1]) == "F" &&
                caps(window[2]) == "R" && caps(window[3]) == "O" && caps(window[4]) == "M")
                phase = PH_NAME_START;
        endfunction

        function void word_spec(input logic [PH_W-1:0] ph, output string txt,
                                output logic [PH_W-1:0] nxt, output logic [1:0] knd);
            txt = "";
            nxt = PH_LEAD;
            knd = WK_NONE;
            case (ph)
                PH_K_SELECT: begin
                    txt = "SELECT";   nxt = PH_SCAN;       knd = WK_KEY;
                end
                PH_K_INSERT: begin
                    txt = "INSERT";   nxt = PH_OPT_INTO;   knd = WK_KEY;
                end
                PH_K_UPDATE: begin
                    txt = "UPDATE";   nxt = PH_NAME_START; knd = WK_KEY;
                end
                PH_K_DELETE: begin
                    txt = "DELETE";   nxt = PH_OPT_FROM;   knd = WK_KEY;
                end
                PH_K_DROP: begin
                    txt = "DROP";     nxt = PH_REQ_TABLE;  knd = WK_KEY;
                end
                PH_K_TRUNCATE: begin
                    txt = "TRUNCATE"; nxt = PH_OPT_TABLE;  knd = WK_KEY;
                end
                PH_K_RECLAIM: begin
                    txt = "RECLAIM";  nxt = PH_OPT_TABLE;  knd = WK_KEY;
                end
                PH_OPT_INTO: begin
                    txt = "INTO";     nxt = PH_NAME_START; knd = WK_OPT;
                end
                PH_OPT_FROM: begin
                    txt = "FROM";     nxt = PH_NAME_START; knd = WK_OPT;
                end
                PH_REQ_TABLE: begin
                    txt = "TABLE";    nxt = PH_OPT_IF;     knd = WK_REQ;
                end
                PH_OPT_IF: begin
                    txt = "IF";       nxt = PH_OPT_EXISTS; knd = WK_OPT;
                end
                PH_OPT_EXISTS: begin
                    txt = "EXISTS";   nxt = PH_NAME_START; knd = WK_OPT;
                end
                PH_OPT_TABLE: begin
                    txt = "TABLE";    nxt = PH_NAME_START; knd = WK_OPT;
                end
                default: begin
                    txt = "";
                end
            endcase
        endfunction

        function void word(input logic [7:0] c);
            string           txt;
            logic [PH_W-1:0] nxt;
            logic [1:0]      knd;
            int              pos;
            word_spec(phase, txt, nxt, knd);
            pos = kw_pos & 7;
            if (phase == PH_K_DELETE && pos == 1 && caps(c) == "R") begin
                phase  = PH_K_DROP;
                kw_pos = 2;
                return;
            end
            if (knd != WK_KEY && pos == 0 && blank(c)) return;
            if (pos < txt.len() && caps(c) == txt[pos]) begin
                if (knd == WK_OPT && pos < 5) begin
                    held[pos] = c;
                    held_n    = pos + 1;
                end
                pos++;
                if (pos >= txt.len()) begin
                    phase  = nxt;
                    kw_pos = 0;
                    held_n = 0;
                end else begin
                    kw_pos = pos;
                end
                return;
            end
            if (knd != WK_OPT) begin
                phase = PH_DONE;
                return;
            end
            if (held_n > 0) begin
                flush_held();
                if (phase == PH_NAME) bare(c);
            end else begin
                kw_pos = 0;
                phase  = PH_NAME_START;
                name_begin(c);
            end
        endfunction

        function void take(input logic [7:0] c);
            if (phase == PH_LEAD) begin
                lead(c);
            end else if (phase == PH_SCAN) begin
                scan(c);
            end else if (phase < PH_NAME_START) begin
                word(c);
            end else if (phase == PH_NAME_START) begin
                name_begin(c);
            end else if (phase == PH_NAME) begin
                if (quoted) begin
                    if (c == CH_DQUOTE) phase = PH_DONE;
                    else name_out(c);
                end else begin
                    bare(c);
                end
            end
        endfunction

        function void note_byte(input logic [7:0] c, input logic stmt_end);
            int i;
            step_q.delete();
            if (c == CH_NUL) begin
                if (held_n > 0) flush_held();
                phase = PH_DONE;
            end else if (phase != PH_DONE) begin
                take(c);
            end
            for (i = 0; i < 4; i++) window[i] = window[i + 1];
            window[4] = c;
            if (stmt_end) begin
                if (held_n > 0) flush_held();
                put(RK_VERDICT, 8'h00, name_n > 0);
                clear_state();
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i]) awaited.push_back(step_q[i]);
        endfunction

        function void check_result(input logic kind, input logic [15:0] data,
                                   input logic stmt_last);
            name_result_t want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0b byte %02h found %0b last %0b",
                             kind, data[7:0], data[8], stmt_last);
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind || data[7:0] !== want.name_chr ||
                data[8] !== want.found || stmt_last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display({"result differs: expected kind %0b byte %02h found %0b last %0b,",
                              " got kind %0b byte %02h found %0b last %0b"},
                             want.kind, want.name_chr, want.found, want.last,
                             kind, data[7:0], data[8], stmt_last);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    table_name_board board = new();

    logic [7:0] stmt_text[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         sent_items     = 0;
    logic       hold_token     = 1'b0;
    logic       seen_token     = 1'b0;
    int         hold_left      = 0;

    sql_target_table_extractor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
        end
    end

    // hold off the result side for a long stretch on request, else stall at random
    always @(posedge aclk) begin
        if (hold_token != seen_token) begin
            seen_token <= hold_token;
            hold_left  <= 90;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) return c + 8'd32;
        return c;
    endfunction

    function automatic void add_word(input string w, input int n, input bit mixed);
        int i;
        for (i = 0; i < n; i++) stmt_text.push_back(mixed ? mix_case(w[i]) : w[i]);
    endfunction

    function automatic void add_blank(input int lo, input int hi);
        int r;
        repeat ($urandom_range(lo, hi)) begin
            r = $urandom_range(0, 9);
            stmt_text.push_back(r < 5 ? 8'(9 + r) : CH_SPACE);
        end
    endfunction

    function automatic void add_opt(input string w);
        int r;
        r = $urandom_range(0, 3);
        if (r == 1 || r == 2) begin
            add_word(w, w.len(), 1);
            add_blank(1, 2);
        end else if (r == 3) begin
            add_word(w, $urandom_range(1, w.len() - 1), 1);
        end
    endfunction

    function automatic void add_name();
        string      chars;
        bit         q;
        logic [7:0] c;
        chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        q = ($urandom_range(0, 4) == 0);
        if (q) stmt_text.push_back(CH_DQUOTE);
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(1, 255));
            else c = chars[$urandom_range(0, chars.len() - 1)];
            if (q && c == CH_DQUOTE) c = "_";
            stmt_text.push_back(c);
        end
        if (q && $urandom_range(0, 3) != 0) stmt_text.push_back(CH_DQUOTE);
    endfunction

    function automatic void build_stmt();
        string kw [7];
        int    cmd;
        int    r;
        kw = '{"SELECT", "INSERT", "UPDATE", "DELETE", "DROP", "TRUNCATE", "RECLAIM"};
        stmt_text.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) stmt_text.push_back(8'($urandom_range(1, 255)));
            return;
        end
        add_blank(0, 2);
        cmd = $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) begin
            add_word(kw[cmd], $urandom_range(1, kw[cmd].len() - 1), 1);
            stmt_text.push_back(8'($urandom_range(1, 255)));
        end else begin
            add_word(kw[cmd], kw[cmd].len(), 1);
        end
        add_blank(0, 2);
        case (cmd)
            0: begin
                if ($urandom_range(0, 1) == 1) stmt_text.push_back("*");
                else add_name();
                add_blank(1, 2);
                r = $urandom_range(0, 7);
                if (r != 0) begin
                    add_word("FROM", 4, 1);
                    add_blank(r == 1 ? 0 : 1, 2);
                end
            end
            1: add_opt("INTO");
            3: add_opt("FROM");
            4: begin
                if ($urandom_range(0, 5) != 0) begin
                    add_word("TABLE", 5, 1);
                    add_blank(1, 2);
                    r = $urandom_range(0, 3);
                    if (r >= 2) begin
                        add_word("IF", 2, 1);
                        add_blank(1, 2);
                        add_opt("EXISTS");
                    end else if (r == 1) begin
                        add_opt("IF");
                    end
                end
            end
            5, 6: add_opt("TABLE");
            default: begin
            end
        endcase
        if ($urandom_range(0, 9) != 0) add_name();
        case ($urandom_range(0, 3))
            1: stmt_text.push_back(CH_SEMI);
            2: begin
                add_blank(1, 1);
                stmt_text.push_back(8'($urandom_range(1, 255)));
            end
            3: begin
                stmt_text.push_back(CH_NUL);
                stmt_text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_stmt();
        int i;
        for (i = 0; i < stmt_text.size(); i++) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stmt_text[i];
            s_tlast  <= (i == stmt_text.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent_items++;
        end
    endtask

    task automatic send_text(input string s);
        stmt_text.delete();
        add_word(s, s.len(), 0);
        send_stmt();
    endtask

    initial begin
        int send_pct [4];
        int recv_pct [4];
        int ph;
        int target;
        send_pct = '{0, 51, 0, 19};
        recv_pct = '{0, 0, 51, 19};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text(" \tUpdate T1;x");
        send_text("sElEcT * from \"a b\"");
        send_text("drop table if existz");
        send_text("InSeRt IN");
        send_text("DROP x");
        send_text("what");
        send_text("SELECT a");
        send_text("RECLAIM \"ab");
        stmt_text.delete();
        add_word("DELETE FR", 9, 0);
        stmt_text.push_back(CH_NUL);
        stmt_text.push_back("q");
        send_stmt();
        stmt_text.delete();
        add_word("TRUNCATE ", 9, 0);
        stmt_text.push_back(8'hFF);
        stmt_text.push_back(8'h01);
        send_stmt();

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            target = sent_items + 14;
            if (ph == 0) begin
                // fill the block while the result side is held off
                hold_token <= ~hold_token;
                stmt_text.delete();
                add_word("UPDATE ", 7, 1);
                repeat (24) stmt_text.push_back(8'("a" + $urandom_range(0, 25)));
                send_stmt();
                target = sent_items + 14;
            end
            while (sent_items < target) begin
                build_stmt();
                send_stmt();
            end
        end
        s_tvalid <= 1'b0;

        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.failures == 0) begin
            $display("sql_target_table_extractor: match");
        end else begin
            $display("sql_target_table_extractor: mismatch");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("sql_target_table_extractor: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
design/stx_pkg.sv
design/stx_front.sv
design/stx_queue.sv
design/stx_back.sv
design/sql_target_table_extractor.sv
design/stx_checker.sv
sim/sql_target_table_extractor_tb.sv
